@@ rtl/tcw_pkg.sv @@
// Shared types, constants and helpers for the text console character writer.
// Used by tcw_front, tcw_back and text_console_char_writer; depends on nothing.
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int NCELLS = ROWS * COLS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CELL_W = 16;

  // port widths of the word fields
  localparam int OP_PORT_W  = 2;
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;
  localparam int POS_PORT_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0] RST_FILL_CHAR = 8'h20;
  localparam logic [7:0] RST_FILL_ATTR = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETCUR = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } tcw_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_CHAR = 1'd0,
    REG_FILL_ATTR = 1'd1
  } tcw_reg_e;

  typedef enum logic [2:0] {
    K_NOP,
    K_NL,
    K_CR,
    K_CHAR,
    K_SETCUR,
    K_CLEAR,
    K_READ
  } tcw_kind_e;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } tcw_sweep_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ
  } tcw_state_e;

  typedef struct packed {
    tcw_kind_e        kind;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tcw_cmd_t;

  typedef struct packed {
    logic [7:0] fill_char;
    logic [7:0] fill_attr;
  } tcw_cfg_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS)) + ADDR_W'(c);
  endfunction

endpackage

@@ rtl/tcw_front.sv @@
// Front end: decodes incoming words into commands and queues them (two deep).
// Depends on tcw_pkg.
module tcw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [tcw_pkg::OP_PORT_W-1:0]    opcode_i,
  input  logic [7:0]                       char_code_i,
  input  logic [3:0]                       bg_color_i,
  input  logic [3:0]                       fg_color_i,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]   target_row_i,
  input  logic [tcw_pkg::COL_PORT_W-1:0]   target_col_i,
  input  logic                             init_busy_i,
  output logic                             cmd_valid_o,
  output tcw_pkg::tcw_cmd_t                cmd_o,
  input  logic                             cmd_take_i
);

  tcw_pkg::tcw_cmd_t entry_q [2];
  tcw_pkg::tcw_cmd_t cmd_new;
  logic [1:0]        count_q, count_d;
  logic              wr_ptr_q, rd_ptr_q;
  logic              push_ok;

  always_comb begin
    cmd_new.ch   = char_code_i;
    cmd_new.attr = {bg_color_i, fg_color_i};
    cmd_new.row  = (int'(target_row_i) > tcw_pkg::ROWS - 1) ?
                   tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : tcw_pkg::ROW_W'(target_row_i);
    cmd_new.col  = (int'(target_col_i) > tcw_pkg::COLS - 1) ?
                   tcw_pkg::COL_W'(tcw_pkg::COLS - 1) : tcw_pkg::COL_W'(target_col_i);
    case (tcw_pkg::tcw_op_e'(opcode_i))
      tcw_pkg::OP_PUT: begin
        case (char_code_i) inside
          tcw_pkg::CH_BEL, tcw_pkg::CH_BS, tcw_pkg::CH_TAB,
          tcw_pkg::CH_VT, tcw_pkg::CH_FF: cmd_new.kind = tcw_pkg::K_NOP;
          tcw_pkg::CH_NL:                 cmd_new.kind = tcw_pkg::K_NL;
          tcw_pkg::CH_CR:                 cmd_new.kind = tcw_pkg::K_CR;
          default:                        cmd_new.kind = tcw_pkg::K_CHAR;
        endcase
      end
      tcw_pkg::OP_SETCUR: cmd_new.kind = tcw_pkg::K_SETCUR;
      tcw_pkg::OP_CLEAR:  cmd_new.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ:   cmd_new.kind = tcw_pkg::K_READ;
      default:            cmd_new.kind = tcw_pkg::K_NOP;
    endcase
  end

  // no words taken while the store is being initialized
  assign full        = (count_q == 2'd2) || init_busy_i;
  assign push_ok     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_ok && !(cmd_take_i && cmd_valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push_ok && cmd_take_i && cmd_valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_ok) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_take_i && cmd_valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/tcw_back.sv @@
// Back end: cursor, cell store, sweep sequencer for init/clear/scroll, result word.
// Depends on tcw_pkg.
module tcw_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  tcw_pkg::tcw_cmd_t                cmd_i,
  output logic                             cmd_take_o,
  input  tcw_pkg::tcw_cfg_t                cfg_i,
  output logic                             init_busy_o,
  output logic                             empty,
  input  logic                             pop,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cur_row_o,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cur_col_o,
  output logic [tcw_pkg::POS_PORT_W-1:0]   cur_pos_o,
  output logic [tcw_pkg::CELL_W-1:0]       cell_word_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::CELL_W;

  logic [CW-1:0]  mem_q [tcw_pkg::NCELLS];
  logic [CW-1:0]  rdata_q;

  tcw_pkg::tcw_state_e state_q, state_d;
  tcw_pkg::tcw_sweep_e sweep_q, sweep_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [tcw_pkg::ROW_W-1:0] row_q, row_d;
  logic [tcw_pkg::COL_W-1:0] col_q, col_d;

  logic           pend_q, pend_d;
  logic           pend_blank_q, pend_blank_d;
  logic [AW-1:0]  pend_addr_q;

  logic           res_valid_q;
  logic [tcw_pkg::ROW_W-1:0] res_row_q;
  logic [tcw_pkg::COL_W-1:0] res_col_q;
  logic [AW-1:0]  res_pos_q;
  logic [CW-1:0]  res_cell_q;
  logic           res_load;
  logic [CW-1:0]  res_cell;
  logic           res_room;

  logic           we;
  logic [AW-1:0]  wr_addr;
  logic [CW-1:0]  wr_data;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  blank;
  logic           copy;

  assign blank = (sweep_q == tcw_pkg::SW_INIT) ?
                 {tcw_pkg::RST_FILL_ATTR, tcw_pkg::RST_FILL_CHAR} :
                 {cfg_i.fill_attr, cfg_i.fill_char};
  // scroll copies every row but the last from one row below
  assign copy = (sweep_q == tcw_pkg::SW_SCROLL) &&
                (int'(idx_q) < tcw_pkg::NCELLS - tcw_pkg::COLS);
  assign res_room    = !res_valid_q || pop;
  assign init_busy_o = (state_q != tcw_pkg::ST_IDLE) && (sweep_q == tcw_pkg::SW_INIT);

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    idx_d        = idx_q;
    row_d        = row_q;
    col_d        = col_q;
    cmd_take_o   = 1'b0;
    res_load     = 1'b0;
    res_cell     = '0;
    pend_d       = 1'b0;
    pend_blank_d = 1'b1;
    we           = pend_q;
    wr_addr      = pend_addr_q;
    wr_data      = pend_blank_q ? blank : rdata_q;
    rd_addr      = tcw_pkg::cell_addr(cmd_i.row, cmd_i.col);
    case (state_q)
      tcw_pkg::ST_SWEEP: begin
        pend_d       = 1'b1;
        pend_blank_d = !copy;
        rd_addr      = copy ? idx_q + AW'(tcw_pkg::COLS) : idx_q;
        if (int'(idx_q) == tcw_pkg::NCELLS - 1) begin
          idx_d   = '0;
          state_d = tcw_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      tcw_pkg::ST_DRAIN: begin
        // last sweep write lands here
        res_load = (sweep_q != tcw_pkg::SW_INIT);
        state_d  = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_READ: begin
        res_load = 1'b1;
        res_cell = rdata_q;
        state_d  = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid_i && res_room) begin
          cmd_take_o = 1'b1;
          case (cmd_i.kind)
            tcw_pkg::K_NOP: res_load = 1'b1;
            tcw_pkg::K_CR: begin
              col_d    = '0;
              res_load = 1'b1;
            end
            tcw_pkg::K_NL, tcw_pkg::K_CHAR: begin
              if (cmd_i.kind == tcw_pkg::K_CHAR) begin
                we      = 1'b1;
                wr_addr = tcw_pkg::cell_addr(row_q, col_q);
                wr_data = {cmd_i.attr, cmd_i.ch};
              end
              if (cmd_i.kind == tcw_pkg::K_NL || int'(col_q) == tcw_pkg::COLS - 1) begin
                col_d = '0;
                if (int'(row_q) == tcw_pkg::ROWS - 1) begin
                  sweep_d = tcw_pkg::SW_SCROLL;
                  idx_d   = '0;
                  state_d = tcw_pkg::ST_SWEEP;
                end else begin
                  row_d    = row_q + tcw_pkg::ROW_W'(1);
                  res_load = 1'b1;
                end
              end else begin
                col_d    = col_q + tcw_pkg::COL_W'(1);
                res_load = 1'b1;
              end
            end
            tcw_pkg::K_SETCUR: begin
              row_d    = cmd_i.row;
              col_d    = cmd_i.col;
              res_load = 1'b1;
            end
            tcw_pkg::K_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              sweep_d = tcw_pkg::SW_CLEAR;
              idx_d   = '0;
              state_d = tcw_pkg::ST_SWEEP;
            end
            tcw_pkg::K_READ: state_d = tcw_pkg::ST_READ;
            default: res_load = 1'b1;
          endcase
        end
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_SWEEP;
      sweep_q     <= tcw_pkg::SW_INIT;
      idx_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pend_q  <= pend_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_blank_q <= pend_blank_d;
    pend_addr_q  <= idx_q;
    if (res_load) begin
      res_row_q  <= row_d;
      res_col_q  <= col_d;
      res_pos_q  <= tcw_pkg::cell_addr(row_d, col_d);
      res_cell_q <= res_cell;
    end
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign empty       = !res_valid_q;
  assign cur_row_o   = tcw_pkg::ROW_PORT_W'(res_row_q);
  assign cur_col_o   = tcw_pkg::COL_PORT_W'(res_col_q);
  assign cur_pos_o   = tcw_pkg::POS_PORT_W'(res_pos_q);
  assign cell_word_o = res_cell_q;

endmodule

@@ rtl/text_console_char_writer.sv @@
// Put char, set cursor and ignored codes: the word is queued, then its result word is
// registered; read cell first reads the store (ST_READ); clear and a scrolling put char
// sweep every cell (ST_SWEEP, ST_DRAIN) first. Throughput: one word per cycle into a
// two-deep command queue while full is low; the back end retires one simple command per
// cycle while the result word is free or popped. Reset: cursor homed, blank registers to
// 0x20/0x07, then a clearing pass writes 0x0720 to every cell while full is held high.
module text_console_char_writer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [tcw_pkg::OP_PORT_W-1:0]    opcode_i,
  input  logic [7:0]                       char_code_i,
  input  logic [3:0]                       bg_color_i,
  input  logic [3:0]                       fg_color_i,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]   target_row_i,
  input  logic [tcw_pkg::COL_PORT_W-1:0]   target_col_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cur_row_o,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cur_col_o,
  output logic [tcw_pkg::POS_PORT_W-1:0]   cur_pos_o,
  output logic [tcw_pkg::CELL_W-1:0]       cell_word_o,
  input  logic                             cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tcw_pkg::tcw_cfg_t cfg_q;
  tcw_pkg::tcw_cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_take;
  logic              init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_char <= tcw_pkg::RST_FILL_CHAR;
      cfg_q.fill_attr <= tcw_pkg::RST_FILL_ATTR;
    end else if (cfg_we_i) begin
      case (tcw_pkg::tcw_reg_e'(cfg_idx_i))
        tcw_pkg::REG_FILL_CHAR: cfg_q.fill_char <= cfg_data_i;
        tcw_pkg::REG_FILL_ATTR: cfg_q.fill_attr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .bg_color_i   (bg_color_i),
    .fg_color_i   (fg_color_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .init_busy_i  (init_busy),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_take_i   (cmd_take)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .cfg_i       (cfg_q),
    .init_busy_o (init_busy),
    .empty       (empty),
    .pop         (pop),
    .cur_row_o   (cur_row_o),
    .cur_col_o   (cur_col_o),
    .cur_pos_o   (cur_pos_o),
    .cell_word_o (cell_word_o)
  );

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (int'(cur_row_o) <= tcw_pkg::ROWS - 1) && (int'(cur_col_o) <= tcw_pkg::COLS - 1))
    else $error("cursor out of range in result word");

  a_pos_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> int'(cur_pos_o) == int'(cur_row_o) * tcw_pkg::COLS + int'(cur_col_o))
    else $error("cursor position does not match row and column");

  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> full && empty)
    else $error("words accepted during initialization pass");

  a_no_cmd_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !cmd_take && empty)
    else $error("command executed during initialization pass");

endmodule
